>>> hdl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared constants, tag tables and types for the think-tag stream splitter.
// ----------------------------------------------------------------------------
package tss_pkg;

    // tag lengths (each tag is matched to its full length, 2..8)
    localparam int OPEN_TAG_LEN  = 7;
    localparam int CLOSE_TAG_LEN = 8;

    localparam logic [3:0] OPEN_LEN  = 4'(OPEN_TAG_LEN);
    localparam logic [3:0] CLOSE_LEN = 4'(CLOSE_TAG_LEN);

    // tag bit patterns, padded to eight entries
    localparam logic [7:0] OPEN_TAG [8] = '{8'h3c, 8'h74, 8'h68, 8'h69,
                                            8'h6e, 8'h6b, 8'h3e, 8'h00};
    localparam logic [7:0] CLOSE_TAG [8] = '{8'h3c, 8'h2f, 8'h74, 8'h68,
                                             8'h69, 8'h6e, 8'h6b, 8'h3e};

    // command codes
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // byte classes
    localparam logic CLASS_CONTENT  = 1'b0;
    localparam logic CLASS_THINKING = 1'b1;

    // stream phase, one-hot
    typedef enum logic [2:0] {
        PH_BEFORE = 3'b001,
        PH_THINK  = 3'b010,
        PH_AFTER  = 3'b100
    } phase_t;

    // description of one burst of released bytes
    typedef struct packed {
        logic       load;        // burst has at least one byte
        logic [3:0] cnt;         // total bytes in the burst, 1..8
        logic [2:0] held;        // leading bytes rebuilt from a tag
        logic       held_close;  // tag those bytes come from
        logic       cls;         // class of every byte in the burst
        logic [7:0] data;        // trailing byte when cnt > held
    } run_t;

    // byte idx of the opening or closing tag
    function automatic logic [7:0] tag_byte(input logic is_close, input logic [2:0] idx);
        tag_byte = is_close ? CLOSE_TAG[idx] : OPEN_TAG[idx];
    endfunction

    // held bytes plus the new byte form a prefix of the target tag
    function automatic logic tag_prefix(input logic       tgt_close,
                                        input logic       held_close,
                                        input logic [2:0] held,
                                        input logic [7:0] data);
        logic       ok;
        logic [3:0] n;
        logic [3:0] len;
        ok  = 1'b1;
        n   = {1'b0, held} + 4'd1;
        len = tgt_close ? CLOSE_LEN : OPEN_LEN;
        for (int i = 0; i < 8; i++) begin
            if (3'(i) < held) begin
                ok = ok & (tag_byte(held_close, 3'(i)) == tag_byte(tgt_close, 3'(i)));
            end
        end
        ok = ok & (tag_byte(tgt_close, held) == data) & (n <= len);
        tag_prefix = ok;
    endfunction

endpackage

>>> hdl/tss_if.sv
// ----------------------------------------------------------------------------
// tss_if
// Valid/ready channels for the splitter's text input and released bytes.
// ----------------------------------------------------------------------------
interface tss_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] text_byte;

    modport source (output valid, output command, output text_byte, input ready);
    modport sink   (input valid, input command, input text_byte, output ready);
endinterface

interface tss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_class;
    logic       last_of_run;

    modport source (output valid, output out_byte, output byte_class,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input byte_class,
                    input last_of_run, output ready);
endinterface

>>> hdl/tss_matcher.sv
// ----------------------------------------------------------------------------
// tss_matcher
// Tag matcher: holds phase and tag-prefix state, decides each byte's burst.
// ----------------------------------------------------------------------------
module tss_matcher (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            command,
    input  logic [7:0]      data,
    output tss_pkg::run_t   run
);
    import tss_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [2:0] held_reg, held_next;
    logic       close_reg, close_next;

    logic [3:0] n;
    logic       close_ok;
    logic       open_ok;
    logic       emit;

    // prefix tests against both tags
    assign n        = {1'b0, held_reg} + 4'd1;
    assign close_ok = tag_prefix(1'b1, close_reg, held_reg, data);
    assign open_ok  = tag_prefix(1'b0, close_reg, held_reg, data);

    // next state and burst decision
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        close_next = close_reg;
        emit       = 1'b0;
        run        = '0;
        run.data   = data;
        if (accept) begin
            if (command == CMD_RESTART) begin
                phase_next = PH_BEFORE;
                held_next  = 3'd0;
                close_next = 1'b0;
            end
            else begin
                case (phase_reg)
                    PH_BEFORE, PH_THINK:
                    begin
                        if (close_ok && n == CLOSE_LEN) begin
                            phase_next = PH_AFTER;
                            held_next  = 3'd0;
                            close_next = 1'b0;
                        end
                        else if (phase_reg == PH_BEFORE && open_ok) begin
                            if (n == OPEN_LEN) begin
                                phase_next = PH_THINK;
                                held_next  = 3'd0;
                            end
                            else begin
                                held_next = n[2:0];
                            end
                            close_next = 1'b0;
                        end
                        else if (close_ok) begin
                            held_next  = n[2:0];
                            close_next = 1'b1;
                        end
                        else begin
                            // mismatch: release held bytes, maybe start a new hold
                            run.held       = held_reg;
                            run.held_close = close_reg;
                            run.cls        = (phase_reg == PH_THINK) ? CLASS_THINKING
                                                                     : CLASS_CONTENT;
                            if (phase_reg == PH_BEFORE && data == OPEN_TAG[0]) begin
                                held_next  = 3'd1;
                                close_next = 1'b0;
                            end
                            else if (data == CLOSE_TAG[0]) begin
                                held_next  = 3'd1;
                                close_next = 1'b1;
                            end
                            else begin
                                held_next  = 3'd0;
                                close_next = 1'b0;
                                emit       = 1'b1;
                            end
                            run.cnt  = {1'b0, held_reg} + {3'd0, emit};
                            run.load = (run.cnt != 4'd0);
                        end
                    end
                    default:
                    begin
                        // after thinking every byte is content
                        run.cls  = CLASS_CONTENT;
                        run.cnt  = 4'd1;
                        run.load = 1'b1;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_BEFORE;
            held_reg  <= 3'd0;
            close_reg <= 1'b0;
        end
        else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            close_reg <= close_next;
        end
    end

    // after thinking nothing is ever held
    a_after_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_AFTER |-> held_reg == 3'd0)
        else $error("bytes held after thinking");

    // a hold never reaches the full tag length
    a_hold_short: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, held_reg} < (close_reg ? CLOSE_LEN : OPEN_LEN))
        else $error("held prefix as long as its tag");

    // after thinking is left only by a restart
    a_after_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_AFTER && !(accept && command == CMD_RESTART))
        |=> phase_reg == PH_AFTER)
        else $error("left after-thinking without restart");

endmodule

>>> hdl/think_tag_stream_splitter_core.sv
// ----------------------------------------------------------------------------
// think_tag_stream_splitter_core
// Splits a text byte stream into content and thinking bytes, dropping tags.
// ----------------------------------------------------------------------------
// One input transfer is taken per cycle while the release register is free
// or releasing its last byte. Each byte is matched combinationally against
// the opening and closing tags and yields a burst of zero to eight released
// bytes, handed out by a release register one per cycle while the output is
// ready. A byte that yields one result or none does not slow the input;
// a longer burst holds the input until its last byte is taken, when the
// next burst loads. Partial tag prefixes are held back and rebuilt from the
// tag tables on a mismatch. last_of_run marks the final byte of each burst.
// A restart command clears the phase and any held bytes.
module think_tag_stream_splitter_core (
    input  logic        clk,
    input  logic        rst_n,
    tss_in_if.sink      text_in,
    tss_out_if.source   text_out
);
    import tss_pkg::*;

    run_t       run;
    logic       in_accept;
    logic       out_last;

    logic       run_valid_reg;
    logic [2:0] run_idx_reg;
    logic [3:0] run_cnt_reg;
    logic [2:0] run_held_reg;
    logic       run_close_reg;
    logic       run_cls_reg;
    logic [7:0] run_data_reg;

    // input handshake: free, or the last byte of a burst leaves this cycle
    assign out_last      = ({1'b0, run_idx_reg} + 4'd1) == run_cnt_reg;
    assign text_in.ready = !run_valid_reg || (text_out.ready && out_last);
    assign in_accept     = text_in.valid && text_in.ready;

    tss_matcher u_matcher (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .command (text_in.command),
        .data    (text_in.text_byte),
        .run     (run)
    );

    // release control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_valid_reg <= 1'b0;
            run_idx_reg   <= 3'd0;
        end
        else if (in_accept && run.load) begin
            run_valid_reg <= 1'b1;
            run_idx_reg   <= 3'd0;
        end
        else if (run_valid_reg && text_out.ready) begin
            if (out_last) begin
                run_valid_reg <= 1'b0;
            end
            else begin
                run_idx_reg <= run_idx_reg + 3'd1;
            end
        end
    end

    // burst payload
    always_ff @(posedge clk)
    begin
        if (in_accept && run.load) begin
            run_cnt_reg   <= run.cnt;
            run_held_reg  <= run.held;
            run_close_reg <= run.held_close;
            run_cls_reg   <= run.cls;
            run_data_reg  <= run.data;
        end
    end

    // output transfer
    assign text_out.valid       = run_valid_reg;
    assign text_out.out_byte    = (run_idx_reg < run_held_reg)
                                  ? tag_byte(run_close_reg, run_idx_reg) : run_data_reg;
    assign text_out.byte_class  = run_cls_reg;
    assign text_out.last_of_run = out_last;

    // a live burst has between one and eight bytes
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> (run_cnt_reg != 4'd0 && run_cnt_reg <= 4'd8))
        else $error("burst count out of range");

    // the release index stays inside the burst
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> {1'b0, run_idx_reg} < run_cnt_reg)
        else $error("release index past burst end");

    // held bytes never exceed the burst length
    a_held_fits: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> {1'b0, run_held_reg} <= run_cnt_reg)
        else $error("held bytes exceed burst");

    // a byte taken mid-burst advances the index by one
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (run_valid_reg && text_out.ready && !out_last)
        |=> run_valid_reg && run_idx_reg == $past(run_idx_reg) + 3'd1)
        else $error("release index skipped");

endmodule

>>> sim/tss_release_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tss_release_checker
// Watches both channels of the think-tag splitter, predicts the released
// bytes for every accepted input transfer and compares each output transfer
// against the oldest prediction. Counts failures for the testbench top.
// ----------------------------------------------------------------------------
module tss_release_checker (
    input  logic clk,
    input  logic rst_n,
    tss_in_if    text_in,
    tss_out_if   text_out,
    output int   errors,
    output int   pending
);
    import tss_pkg::*;

    // one predicted released byte
    typedef struct packed {
        logic [7:0] data;
        logic       cls;
        logic       last;
    } release_t;

    release_t   release_q [$];

    // splitter state as predicted
    phase_t     phase      = PH_BEFORE;
    logic [2:0] held_cnt   = 3'd0;
    logic       held_close = 1'b0;

    // does seq[0..n-1] start the opening or closing tag
    function automatic bit starts_tag(input bit is_close, input logic [7:0] seq [9],
                                      input int n);
        int tag_len;
        tag_len = is_close ? CLOSE_TAG_LEN : OPEN_TAG_LEN;
        if (n > tag_len)
            return 0;
        for (int i = 0; i < n; i++)
        begin
            if (seq[i] != (is_close ? CLOSE_TAG[i] : OPEN_TAG[i]))
                return 0;
        end
        return 1;
    endfunction

    // work out the bytes released by one input transfer
    task automatic predict_release(input logic cmd, input logic [7:0] b);
        logic [7:0] seq [9];
        int         n;
        int         first;
        bit         open_ok;
        bit         close_ok;
        logic       cls;

        if (cmd == CMD_RESTART)
        begin
            phase      = PH_BEFORE;
            held_cnt   = 3'd0;
            held_close = 1'b0;
            return;
        end

        // after thinking everything passes straight through as content
        if (phase == PH_AFTER)
        begin
            release_q.push_back('{data: b, cls: CLASS_CONTENT, last: 1'b1});
            return;
        end

        // rebuild the held prefix and append the new byte
        for (int i = 0; i < 9; i++)
            seq[i] = 8'h00;
        for (int i = 0; i < int'(held_cnt); i++)
            seq[i] = held_close ? CLOSE_TAG[i] : OPEN_TAG[i];
        seq[held_cnt] = b;
        n        = int'(held_cnt) + 1;
        close_ok = starts_tag(1'b1, seq, n);
        open_ok  = starts_tag(1'b0, seq, n);

        // closing tag complete, orphan or not
        if (close_ok && n == CLOSE_TAG_LEN)
        begin
            phase      = PH_AFTER;
            held_cnt   = 3'd0;
            held_close = 1'b0;
            return;
        end

        // opening tag only counts before thinking; a lone '<' lands here
        if (phase == PH_BEFORE && open_ok)
        begin
            if (n == OPEN_TAG_LEN)
            begin
                phase    = PH_THINK;
                held_cnt = 3'd0;
            end
            else
            begin
                held_cnt = 3'(n);
            end
            held_close = 1'b0;
            return;
        end

        if (close_ok)
        begin
            held_cnt   = 3'(n);
            held_close = 1'b1;
            return;
        end

        // mismatch: flush the held prefix in the current class
        cls   = (phase == PH_THINK) ? CLASS_THINKING : CLASS_CONTENT;
        first = release_q.size();
        for (int i = 0; i < int'(held_cnt); i++)
            release_q.push_back('{data: seq[i], cls: cls, last: 1'b0});
        held_cnt   = 3'd0;
        held_close = 1'b0;

        // a fresh '<' starts a new hold instead of being released
        if (phase == PH_BEFORE && b == OPEN_TAG[0])
        begin
            held_cnt   = 3'd1;
            held_close = 1'b0;
        end
        else if (b == CLOSE_TAG[0])
        begin
            held_cnt   = 3'd1;
            held_close = 1'b1;
        end
        else
        begin
            release_q.push_back('{data: b, cls: cls, last: 1'b0});
        end

        if (release_q.size() > first)
            release_q[$].last = 1'b1;
    endtask

    // sample both channels at each rising edge
    always @(posedge clk)
    begin
        release_t exp_r;
        int       bad;
        if (rst_n)
        begin
            bad = 0;
            if (text_out.valid && text_out.ready)
            begin
                if (release_q.size() == 0)
                begin
                    $display("%0t checker: unexpected transfer, byte %02h class %0b last %0b",
                             $time, text_out.out_byte, text_out.byte_class,
                             text_out.last_of_run);
                    bad++;
                end
                else
                begin
                    exp_r = release_q.pop_front();
                    if (text_out.out_byte !== exp_r.data)
                    begin
                        $display("%0t checker: out_byte expected %02h actual %02h",
                                 $time, exp_r.data, text_out.out_byte);
                        bad++;
                    end
                    if (text_out.byte_class !== exp_r.cls)
                    begin
                        $display("%0t checker: byte_class expected %0b actual %0b",
                                 $time, exp_r.cls, text_out.byte_class);
                        bad++;
                    end
                    if (text_out.last_of_run !== exp_r.last)
                    begin
                        $display("%0t checker: last_of_run expected %0b actual %0b",
                                 $time, exp_r.last, text_out.last_of_run);
                        bad++;
                    end
                end
            end
            if (text_in.valid && text_in.ready)
                predict_release(text_in.command, text_in.text_byte);
            errors  <= errors + bad;
            pending <= release_q.size();
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the think-tag stream splitter. A directed run
// walks through tag entry, exit, orphan close, longest flush and restart;
// a random run then mixes whole tags, broken tags, noise and restarts,
// with random idle gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb;
    import tss_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   sent;
    bit   steady;

    tss_in_if  text_in ();
    tss_out_if text_out ();

    think_tag_stream_splitter_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .text_out (text_out)
    );

    tss_release_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .text_out (text_out),
        .errors   (errors),
        .pending  (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    // random text biased towards tag characters
    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return OPEN_TAG[0];
        if (r < 20)
            return CLOSE_TAG[1];
        if (r < 32)
            return CLOSE_TAG[$urandom_range(2, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    // output stalls
    initial
    begin
        int stall;
        stall = 0;
        text_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                text_out.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 99) < 20)
            begin
                stall = gap_len();
                text_out.ready <= 1'b0;
            end
            else
            begin
                text_out.ready <= 1'b1;
            end
        end
    end

    // one input transfer, after an optional idle gap
    task automatic send(input logic cmd, input logic [7:0] b);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            text_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_in.valid     <= 1'b1;
        text_in.command   <= cmd;
        text_in.text_byte <= b;
        do
            @(posedge clk);
        while (!text_in.ready);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send(CMD_BYTE, s[i]);
    endtask

    // whole tag, or a tag broken off after a random prefix
    task automatic send_tag(input bit is_close, input bit broken);
        int tag_len;
        int cut;
        tag_len = is_close ? CLOSE_TAG_LEN : OPEN_TAG_LEN;
        cut     = broken ? $urandom_range(1, tag_len - 1) : tag_len;
        for (int i = 0; i < cut; i++)
            send(CMD_BYTE, is_close ? CLOSE_TAG[i] : OPEN_TAG[i]);
        if (broken)
            send(CMD_BYTE, noise_byte());
    endtask

    // stimulus and verdict
    initial
    begin
        int pick;
        sent               = 0;
        steady             = 1'b0;
        rst_n              = 1'b0;
        text_in.valid     <= 1'b0;
        text_in.command   <= CMD_BYTE;
        text_in.text_byte <= 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // enter thinking, one thinking byte, longest flush in thinking
        send_text("<think>");
        send(CMD_BYTE, 8'hff);
        send_text("</thinkq");
        // double '<' then a close that completes from the second one
        send_text("<</think>");
        send(CMD_BYTE, 8'h00);
        // restart, then an orphan close straight to after-thinking
        send(CMD_RESTART, 8'hff);
        send_text("</think>");
        send_text("<");
        send(CMD_RESTART, 8'h00);

        // random mix of tags, broken tags, noise and restarts
        while (sent < 300)
        begin
            steady = ($urandom_range(0, 4) == 0);
            pick   = $urandom_range(0, 99);
            if (pick < 5)
                send(CMD_RESTART, 8'($urandom_range(0, 255)));
            else if (pick < 25)
                send_tag(1'b0, 1'b0);
            else if (pick < 45)
                send_tag(1'b1, 1'b0);
            else if (pick < 65)
                send_tag(1'($urandom_range(0, 1)), 1'b1);
            else
                repeat ($urandom_range(1, 6)) send(CMD_BYTE, noise_byte());
        end
        text_in.valid <= 1'b0;
        steady = 1'b0;

        // drain, then give late extra transfers a chance to show
        do
            @(posedge clk);
        while (pending != 0);
        repeat (40) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
